>>> hdl/ihx_pkg.sv
// Package with the shared types, constants and helper functions of the incremental hash.
`default_nettype none

package ihx_pkg;

	localparam logic [63:0] MULT_A = 64'h87c37b91114253d5;
	localparam logic [63:0] MULT_B = 64'h4cf5ad432745937f;
	localparam logic [63:0] ADD_ONE = 64'h0000000052dce729;
	localparam logic [63:0] ADD_TWO = 64'h0000000038495ab5;
	localparam logic [63:0] FMIX_A = 64'hff51afd7ed558ccd;
	localparam logic [63:0] FMIX_B = 64'hc4ceb9fe1a85ec53;

	localparam int unsigned ROT_K1 = 31;
	localparam int unsigned ROT_K2 = 33;
	localparam int unsigned ROT_L1 = 27;
	localparam int unsigned ROT_L2 = 31;
	localparam int unsigned FMIX_SHIFT = 33;

	localparam logic [4:0] FULL_BYTES = 5'd16;
	localparam logic [4:0] WORD_BYTES = 5'd8;

	localparam logic MODE_ABSORB = 1'b0;
	localparam logic MODE_FINAL = 1'b1;

	typedef enum logic [1:0] {
		KIND_FULL,
		KIND_TAIL,
		KIND_FINAL
	} ihx_kind_t;

	typedef struct packed {
		logic mode;
		logic [63:0] word_low;
		logic [63:0] word_high;
		logic [4:0] valid_bytes;
	} ihx_in_t;

	typedef struct packed {
		logic [63:0] hash_low;
		logic [63:0] hash_high;
	} ihx_out_t;

	typedef struct packed {
		ihx_kind_t kind;
		logic [4:0] byte_count;
		logic [63:0] k1;
		logic [63:0] k2;
	} ihx_entry_t;

	function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
		return (x << r) | (x >> (64 - r));
	endfunction

	function automatic logic [63:0] keep_bytes(input logic [63:0] w, input logic [4:0] n);
		logic [63:0] r;
		r = '0;
		for (int i = 0; i < 8; i++) begin
			if (5'(i) < n) begin
				r[i*8 +: 8] = w[i*8 +: 8];
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] shift_xor(input logic [63:0] x);
		return x ^ (x >> FMIX_SHIFT);
	endfunction

endpackage

`default_nettype wire

>>> hdl/ihx_mul64.sv
// Two-stage 64 by 64 multiplier that keeps the low 64 bits of the product.
`default_nettype none

module ihx_mul64 (
	input wire logic clk,
	input wire logic [63:0] a_in,
	input wire logic [63:0] b_in,
	output logic [63:0] prod
);

	logic [63:0] ll_s1;
	logic [31:0] lh_s1;
	logic [31:0] hl_s1;
	logic [63:0] prod_s2;

	always_ff @(posedge clk) begin
		ll_s1 <= {32'b0, a_in[31:0]} * {32'b0, b_in[31:0]};
		lh_s1 <= a_in[31:0] * b_in[63:32];
		hl_s1 <= a_in[63:32] * b_in[31:0];
		prod_s2 <= ll_s1 + {lh_s1 + hl_s1, 32'b0};
	end

	assign prod = prod_s2;

endmodule

`default_nettype wire

>>> hdl/ihx_front.sv
// Front part: accepts transactions, masks tail bytes and premixes both chunk words.
`default_nettype none

module ihx_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire ihx_pkg::ihx_in_t in_data,
	output logic push,
	input wire logic full,
	output ihx_pkg::ihx_entry_t push_entry
);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_RUN = 3'b010,
		F_PUSH = 3'b100
	} front_state_t;

	localparam logic [3:0] STEP_ROT1 = 4'd2;
	localparam logic [3:0] STEP_K1 = 4'd5;
	localparam logic [3:0] STEP_ROT2 = 4'd8;
	localparam logic [3:0] STEP_K2 = 4'd11;

	front_state_t state_q;
	logic [3:0] step_q;
	ihx_pkg::ihx_kind_t kind_q;
	logic [4:0] count_q;
	logic [63:0] k1_q;
	logic [63:0] k2_q;
	logic [63:0] w1m_q;
	logic [63:0] op_a_q;
	logic [63:0] op_b_q;
	logic [63:0] prod;
	logic [4:0] n_eff;
	logic [4:0] n_high;
	logic accept;

	ihx_mul64 u_mul (
		.clk(clk),
		.a_in(op_a_q),
		.b_in(op_b_q),
		.prod(prod)
	);

	assign in_ready = (state_q == F_IDLE);
	assign accept = in_valid && in_ready;
	assign n_eff = (in_data.valid_bytes > ihx_pkg::FULL_BYTES) ? ihx_pkg::FULL_BYTES
		: in_data.valid_bytes;
	assign n_high = (n_eff > ihx_pkg::WORD_BYTES) ? n_eff - ihx_pkg::WORD_BYTES : 5'd0;
	assign push = (state_q == F_PUSH) && !full;

	always_comb begin
		push_entry.kind = kind_q;
		push_entry.byte_count = count_q;
		push_entry.k1 = k1_q;
		push_entry.k2 = k2_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q <= 4'd0;
		end else begin
			case (state_q)
				F_IDLE: begin
					step_q <= 4'd0;
					if (accept) begin
						if (in_data.mode == ihx_pkg::MODE_FINAL) begin
							state_q <= F_PUSH;
						end else if (n_eff != 5'd0) begin
							state_q <= F_RUN;
						end
					end
				end
				F_RUN: begin
					step_q <= step_q + 4'd1;
					if (step_q == STEP_K2) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					if (in_data.mode == ihx_pkg::MODE_FINAL) begin
						kind_q <= ihx_pkg::KIND_FINAL;
						count_q <= 5'd0;
					end else begin
						kind_q <= (n_eff == ihx_pkg::FULL_BYTES) ? ihx_pkg::KIND_FULL
							: ihx_pkg::KIND_TAIL;
						count_q <= n_eff;
					end
					w1m_q <= ihx_pkg::keep_bytes(in_data.word_high, n_high);
					op_a_q <= ihx_pkg::keep_bytes(in_data.word_low, n_eff);
					op_b_q <= ihx_pkg::MULT_A;
				end
			end
			F_RUN: begin
				case (step_q)
					STEP_ROT1: begin
						op_a_q <= ihx_pkg::rotl64(prod, ihx_pkg::ROT_K1);
						op_b_q <= ihx_pkg::MULT_B;
					end
					STEP_K1: begin
						k1_q <= prod;
						op_a_q <= w1m_q;
						op_b_q <= ihx_pkg::MULT_B;
					end
					STEP_ROT2: begin
						op_a_q <= ihx_pkg::rotl64(prod, ihx_pkg::ROT_K2);
						op_b_q <= ihx_pkg::MULT_A;
					end
					STEP_K2: begin
						k2_q <= prod;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hdl/ihx_queue.sv
// Small first-in first-out queue of classified transactions between front and back.
`default_nettype none

module ihx_queue #(
	parameter int unsigned DEPTH = 2
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire ihx_pkg::ihx_entry_t push_entry,
	output logic full,
	input wire logic pop,
	output logic pop_valid,
	output ihx_pkg::ihx_entry_t pop_entry
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	ihx_pkg::ihx_entry_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign full = (count_q == CW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("Queue written while full.");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> pop_valid)
		else $error("Queue read while empty.");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("Queue count beyond its depth.");

endmodule

`default_nettype wire

>>> hdl/ihx_back.sv
// Back part: holds the hash lanes and byte total, runs block rounds and the final mix.
`default_nettype none

module ihx_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [31:0] cfg_data,
	input wire logic q_valid,
	input wire ihx_pkg::ihx_entry_t q_entry,
	output logic q_pop,
	output logic out_valid,
	input wire logic out_ready,
	output ihx_pkg::ihx_out_t out_data
);

	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_ABSORB = 4'b0010,
		B_FINAL = 4'b0100,
		B_OUT = 4'b1000
	} back_state_t;

	localparam logic [3:0] STEP_L1_ADD = 4'd0;
	localparam logic [3:0] STEP_L1_MUL = 4'd1;
	localparam logic [3:0] STEP_L2_ADD = 4'd2;
	localparam logic [3:0] STEP_L2_MUL = 4'd3;

	localparam logic [3:0] STEP_ADD_A = 4'd0;
	localparam logic [3:0] STEP_ADD_B = 4'd1;
	localparam logic [3:0] STEP_MA1 = 4'd2;
	localparam logic [3:0] STEP_MB1 = 4'd3;
	localparam logic [3:0] STEP_MA2 = 4'd5;
	localparam logic [3:0] STEP_MB2 = 4'd6;
	localparam logic [3:0] STEP_RA = 4'd8;
	localparam logic [3:0] STEP_RB = 4'd9;
	localparam logic [3:0] STEP_SUM = 4'd10;

	back_state_t state_q;
	logic [3:0] step_q;
	logic [31:0] seed_q;
	logic [63:0] lane_one_q;
	logic [63:0] lane_two_q;
	logic [63:0] byte_total_q;
	logic out_valid_q;
	ihx_pkg::ihx_out_t out_data_q;
	logic [63:0] k1_q;
	logic [63:0] k2_q;
	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] op_a_q;
	logic [63:0] op_b_q;
	logic [63:0] prod;
	logic out_free;

	ihx_mul64 u_mul (
		.clk(clk),
		.a_in(op_a_q),
		.b_in(op_b_q),
		.prod(prod)
	);

	assign q_pop = (state_q == B_IDLE) && q_valid;
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			step_q <= 4'd0;
			seed_q <= 32'd0;
			lane_one_q <= 64'd0;
			lane_two_q <= 64'd0;
			byte_total_q <= 64'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready && state_q != B_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					step_q <= 4'd0;
					if (q_valid) begin
						byte_total_q <= byte_total_q + {59'd0, q_entry.byte_count};
						case (q_entry.kind)
							ihx_pkg::KIND_FULL: begin
								state_q <= B_ABSORB;
							end
							ihx_pkg::KIND_TAIL: begin
								lane_one_q <= lane_one_q ^ q_entry.k1;
								if (q_entry.byte_count > ihx_pkg::WORD_BYTES) begin
									lane_two_q <= lane_two_q ^ q_entry.k2;
								end
							end
							ihx_pkg::KIND_FINAL: begin
								state_q <= B_FINAL;
							end
							default: begin
							end
						endcase
					end
				end
				B_ABSORB: begin
					step_q <= step_q + 4'd1;
					case (step_q)
						STEP_L1_ADD: begin
							lane_one_q <= ihx_pkg::rotl64(lane_one_q ^ k1_q, ihx_pkg::ROT_L1)
								+ lane_two_q;
						end
						STEP_L1_MUL: begin
							lane_one_q <= lane_one_q + (lane_one_q << 2) + ihx_pkg::ADD_ONE;
						end
						STEP_L2_ADD: begin
							lane_two_q <= ihx_pkg::rotl64(lane_two_q ^ k2_q, ihx_pkg::ROT_L2)
								+ lane_one_q;
						end
						STEP_L2_MUL: begin
							lane_two_q <= lane_two_q + (lane_two_q << 2) + ihx_pkg::ADD_TWO;
							state_q <= B_IDLE;
						end
						default: begin
							state_q <= B_IDLE;
						end
					endcase
				end
				B_FINAL: begin
					step_q <= step_q + 4'd1;
					if (step_q == STEP_SUM) begin
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						lane_one_q <= {32'd0, seed_q};
						lane_two_q <= {32'd0, seed_q};
						byte_total_q <= 64'd0;
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
			if (cfg_we) begin
				seed_q <= cfg_data;
				lane_one_q <= {32'd0, cfg_data};
				lane_two_q <= {32'd0, cfg_data};
				byte_total_q <= 64'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					k1_q <= q_entry.k1;
					k2_q <= q_entry.k2;
					a_q <= lane_one_q ^ byte_total_q;
					b_q <= lane_two_q ^ byte_total_q;
				end
			end
			B_FINAL: begin
				case (step_q)
					STEP_ADD_A: begin
						a_q <= a_q + b_q;
					end
					STEP_ADD_B: begin
						b_q <= b_q + a_q;
					end
					STEP_MA1: begin
						op_a_q <= ihx_pkg::shift_xor(a_q);
						op_b_q <= ihx_pkg::FMIX_A;
					end
					STEP_MB1: begin
						op_a_q <= ihx_pkg::shift_xor(b_q);
						op_b_q <= ihx_pkg::FMIX_A;
					end
					STEP_MA2, STEP_MB2: begin
						op_a_q <= ihx_pkg::shift_xor(prod);
						op_b_q <= ihx_pkg::FMIX_B;
					end
					STEP_RA: begin
						a_q <= ihx_pkg::shift_xor(prod);
					end
					STEP_RB: begin
						b_q <= ihx_pkg::shift_xor(prod);
					end
					STEP_SUM: begin
						a_q <= a_q + b_q;
					end
					default: begin
					end
				endcase
			end
			B_OUT: begin
				if (out_free) begin
					out_data_q.hash_low <= a_q;
					out_data_q.hash_high <= b_q + a_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_total_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_OUT && out_free) |=> (byte_total_q == 64'd0))
		else $error("Byte total not cleared after a hash was emitted.");
	a_out_from_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == B_OUT))
		else $error("Result raised outside the output step.");
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (lane_one_q == lane_two_q && byte_total_q == 64'd0))
		else $error("Seed write did not restart the hash state.");

endmodule

`default_nettype wire

>>> hdl/incremental_hash_x64_128.sv
// Incremental 128-bit hash with two 64-bit lanes: top level joining front, queue and back.
//
// Input transactions carry a mode, two 64-bit little-endian chunk words and a byte count.
// An absorb of 16 bytes or more runs the block round, one to fifteen bytes run the tail
// mixing, zero bytes change nothing. A finalize transaction emits one output transaction
// with both hash words and restarts the hash from the seed with a zero byte total.
// Writing cfg_data with cfg_we loads the seed into both lanes and clears the total; the
// user must write it only while the block is idle, which the block does not enforce.
// The front premixes both words with one shared two-stage multiplier in four passes and
// takes no new chunk until the last one is in the queue; a finalize is pushed without
// premixing, and a zero-byte absorb leaves the front ready at once. The back runs a block
// round per full chunk, folds a tail chunk into the lanes, and runs the final mix of a
// finalize on the back's own multiplier.
// The output register holds a result while out_ready is low; the front and queue keep
// taking absorbs meanwhile, and only a second finalize waits for the register to free.
// Reset sets the seed, both lanes and the byte total to zero and empties the queue.
`default_nettype none

module incremental_hash_x64_128 #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [31:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire ihx_pkg::ihx_in_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output ihx_pkg::ihx_out_t out_data
);

	logic push;
	logic full;
	ihx_pkg::ihx_entry_t push_entry;
	logic q_valid;
	logic q_pop;
	ihx_pkg::ihx_entry_t q_entry;

	ihx_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.push(push),
		.full(full),
		.push_entry(push_entry)
	);

	ihx_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.full(full),
		.pop(q_pop),
		.pop_valid(q_valid),
		.pop_entry(q_entry)
	);

	ihx_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.q_valid(q_valid),
		.q_entry(q_entry),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule

`default_nettype wire

>>> bench/ihx_checker.sv
// Checker that predicts the incremental hash results and compares them with the block's output.
`timescale 1ns / 100ps

module ihx_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [31:0] cfg_data,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire ihx_pkg::ihx_in_t in_data,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire ihx_pkg::ihx_out_t out_data,
	output int fail_count,
	output int pending,
	output int checked
);

	logic [63:0] cur_seed;
	logic [63:0] acc_one;
	logic [63:0] acc_two;
	logic [63:0] length_sum;
	ihx_pkg::ihx_out_t expected_hashes[$];
	ihx_pkg::ihx_out_t want;
	ihx_pkg::ihx_out_t fresh;

	function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
		logic [127:0] doubled;
		doubled = {x, x} << r;
		return doubled[127:64];
	endfunction

	function automatic logic [63:0] fold_word_one(input logic [63:0] k);
		logic [63:0] t;
		t = k * ihx_pkg::MULT_A;
		t = rotl(t, ihx_pkg::ROT_K1);
		return t * ihx_pkg::MULT_B;
	endfunction

	function automatic logic [63:0] fold_word_two(input logic [63:0] k);
		logic [63:0] t;
		t = k * ihx_pkg::MULT_B;
		t = rotl(t, ihx_pkg::ROT_K2);
		return t * ihx_pkg::MULT_A;
	endfunction

	function automatic logic [63:0] avalanche64(input logic [63:0] k);
		logic [63:0] t;
		t = k ^ (k >> 33);
		t = t * ihx_pkg::FMIX_A;
		t = t ^ (t >> 33);
		t = t * ihx_pkg::FMIX_B;
		return t ^ (t >> 33);
	endfunction

	function automatic logic [63:0] keep_low_bytes(input logic [63:0] w, input int n);
		if (n >= 8) begin
			return w;
		end
		return w & ((64'd1 << (8 * n)) - 64'd1);
	endfunction

	task automatic restart_hash();
		acc_one = cur_seed;
		acc_two = cur_seed;
		length_sum = '0;
	endtask

	task automatic absorb_chunk(input ihx_pkg::ihx_in_t it);
		int n;
		n = int'(it.valid_bytes);
		if (n > 16) begin
			n = 16;
		end
		if (n == 16) begin
			acc_one = acc_one ^ fold_word_one(it.word_low);
			acc_one = rotl(acc_one, ihx_pkg::ROT_L1);
			acc_one = acc_one + acc_two;
			acc_one = acc_one * 64'd5 + ihx_pkg::ADD_ONE;
			acc_two = acc_two ^ fold_word_two(it.word_high);
			acc_two = rotl(acc_two, ihx_pkg::ROT_L2);
			acc_two = acc_two + acc_one;
			acc_two = acc_two * 64'd5 + ihx_pkg::ADD_TWO;
		end else if (n > 0) begin
			if (n > 8) begin
				acc_two = acc_two ^ fold_word_two(keep_low_bytes(it.word_high, n - 8));
			end
			acc_one = acc_one ^ fold_word_one(keep_low_bytes(it.word_low, n));
		end
		length_sum = length_sum + 64'(n);
	endtask

	task automatic finish_hash(output ihx_pkg::ihx_out_t h);
		logic [63:0] a;
		logic [63:0] b;
		a = acc_one ^ length_sum;
		b = acc_two ^ length_sum;
		a = a + b;
		b = b + a;
		a = avalanche64(a);
		b = avalanche64(b);
		a = a + b;
		b = b + a;
		h.hash_low = a;
		h.hash_high = b;
		restart_hash();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_seed = '0;
			restart_hash();
			expected_hashes.delete();
			fail_count = 0;
			pending = 0;
			checked = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_hashes.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result, expected none, actual %h %h", $time,
						out_data.hash_low, out_data.hash_high);
				end else begin
					want = expected_hashes.pop_front();
					checked++;
					if (out_data.hash_low !== want.hash_low) begin
						fail_count++;
						$display("%0t: hash_low mismatch, expected %h, actual %h", $time,
							want.hash_low, out_data.hash_low);
					end
					if (out_data.hash_high !== want.hash_high) begin
						fail_count++;
						$display("%0t: hash_high mismatch, expected %h, actual %h", $time,
							want.hash_high, out_data.hash_high);
					end
				end
			end
			if (cfg_we) begin
				cur_seed = {32'd0, cfg_data};
				restart_hash();
			end
			if (in_valid && in_ready) begin
				if (in_data.mode == ihx_pkg::MODE_FINAL) begin
					finish_hash(fresh);
					expected_hashes.push_back(fresh);
				end else begin
					absorb_chunk(in_data);
				end
			end
			pending = expected_hashes.size();
		end
	end

endmodule

>>> bench/tb.sv
// Top of the incremental hash testbench: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 100ps

module tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam logic [63:0] ONES = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	ihx_pkg::ihx_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	ihx_pkg::ihx_out_t out_data;

	int fail_count;
	int pending;
	int checked;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;
	bit hold_req = 1'b0;
	int items_sent = 0;
	int finals_sent = 0;
	int cycle_count = 0;

	incremental_hash_x64_128 u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	ihx_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.fail_count(fail_count),
		.pending(pending),
		.checked(checked)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.", cycle_count, pending);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// The receiver counts a long hold-off itself once one is requested.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic ihx_pkg::ihx_in_t pack_item(input logic mode, input logic [63:0] w0,
			input logic [63:0] w1, input logic [4:0] n);
		ihx_pkg::ihx_in_t it;
		it.mode = mode;
		it.word_low = w0;
		it.word_high = w1;
		it.valid_bytes = n;
		return it;
	endfunction

	task automatic push_item(input ihx_pkg::ihx_in_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		items_sent++;
		if (it.mode == ihx_pkg::MODE_FINAL) begin
			finals_sent++;
		end
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do begin
			@(negedge clk);
		end while (pending != 0);
	endtask

	task automatic settle();
		wait_drained();
		repeat (200) @(negedge clk);
	endtask

	task automatic write_seed(input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_items(input int count);
		int target;
		int nfull;
		target = items_sent + count;
		while (items_sent < target) begin
			if ($urandom_range(0, 99) < 80) begin
				nfull = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
				repeat (nfull) begin
					push_item(pack_item(ihx_pkg::MODE_ABSORB, rand_word(), rand_word(),
						ihx_pkg::FULL_BYTES));
				end
				if ($urandom_range(0, 1) == 1) begin
					push_item(pack_item(ihx_pkg::MODE_ABSORB, rand_word(), rand_word(),
						5'($urandom_range(1, 15))));
				end
				push_item(pack_item(ihx_pkg::MODE_FINAL, rand_word(), rand_word(),
					5'($urandom)));
			end else begin
				push_item(pack_item(1'($urandom), rand_word(), rand_word(), 5'($urandom)));
			end
		end
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_item(pack_item(ihx_pkg::MODE_ABSORB, '0, '0, ihx_pkg::FULL_BYTES));
		push_item(pack_item(ihx_pkg::MODE_ABSORB, ONES, ONES, ihx_pkg::FULL_BYTES));
		push_item(pack_item(ihx_pkg::MODE_FINAL, '0, '0, '0));
		push_item(pack_item(ihx_pkg::MODE_FINAL, ONES, ONES, 5'd31));
		push_item(pack_item(ihx_pkg::MODE_ABSORB, ONES, ONES, 5'd1));
		push_item(pack_item(ihx_pkg::MODE_FINAL, '0, '0, '0));
		push_item(pack_item(ihx_pkg::MODE_ABSORB, ONES, ONES, ihx_pkg::WORD_BYTES));
		push_item(pack_item(ihx_pkg::MODE_FINAL, '0, '0, '0));
		push_item(pack_item(ihx_pkg::MODE_ABSORB, ONES, ONES, 5'd9));
		push_item(pack_item(ihx_pkg::MODE_FINAL, '0, '0, '0));
		push_item(pack_item(ihx_pkg::MODE_ABSORB, ONES, ONES, 5'd15));
		push_item(pack_item(ihx_pkg::MODE_ABSORB, ONES, ONES, 5'd0));
		push_item(pack_item(ihx_pkg::MODE_FINAL, '0, '0, '0));
		push_item(pack_item(ihx_pkg::MODE_ABSORB, rand_word(), rand_word(), 5'd17));
		push_item(pack_item(ihx_pkg::MODE_ABSORB, rand_word(), rand_word(), 5'd31));
		push_item(pack_item(ihx_pkg::MODE_FINAL, rand_word(), rand_word(), ihx_pkg::FULL_BYTES));
		push_item(pack_item(ihx_pkg::MODE_ABSORB, rand_word(), rand_word(), 5'd5));
		push_item(pack_item(ihx_pkg::MODE_ABSORB, rand_word(), rand_word(), ihx_pkg::FULL_BYTES));
		push_item(pack_item(ihx_pkg::MODE_ABSORB, rand_word(), rand_word(), 5'd12));
		push_item(pack_item(ihx_pkg::MODE_FINAL, '0, '0, '0));
		push_item(pack_item(ihx_pkg::MODE_ABSORB, {16{4'ha}}, {16{4'h5}}, ihx_pkg::FULL_BYTES));
		push_item(pack_item(ihx_pkg::MODE_FINAL, {16{4'h5}}, {16{4'ha}}, 5'd10));

		settle();
		write_seed(32'hffffffff);
		send_idle_pct = 30;
		recv_idle_pct = 57;
		random_items(170);
		// Hold the receiver off while the sender keeps offering short hashes.
		hold_req = 1'b1;
		send_idle_pct = 0;
		repeat (6) begin
			push_item(pack_item(ihx_pkg::MODE_ABSORB, rand_word(), rand_word(),
				ihx_pkg::FULL_BYTES));
			push_item(pack_item(ihx_pkg::MODE_FINAL, rand_word(), rand_word(), 5'($urandom)));
		end
		send_idle_pct = 30;
		random_items(160);

		settle();
		write_seed(32'($urandom));
		send_idle_pct = 57;
		recv_idle_pct = 30;
		random_items(170);
		wait_drained();
		random_items(160);

		settle();
		write_seed(32'd0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_items(340);

		wait_drained();
		repeat (50) @(negedge clk);

		$display("Checked %0d hash results from %0d input transactions (%0d finalize).",
			checked, items_sent, finals_sent);
		$display("Seeds zero, all ones and random; both sides idling, a long hold-off and a pause.");
		if (fail_count == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
